// ----- design/qte_pkg.sv -----
// ----------------------------------------------------------------------------
// Quaternion to Euler angles: shared package
// Fixed-point formats, pipeline depths and the arctangent table that the
// CORDIC stages use.
// ----------------------------------------------------------------------------
package qte_pkg;

  // Products and sums carry 30 fraction bits, so one is 2**30.
  localparam int FRAC_BITS = 30;
  localparam int PROD_W    = 34;
  localparam int SUM_W     = 36;

  // CORDIC datapath: normalized vectors, iteration width, angle accumulator.
  localparam int NORM_W    = 42;
  localparam int CORD_W    = 45;
  localparam int ANG_W     = 34;
  localparam int ITERS     = 31;

  // Square root of 2**60 - s**2.
  localparam int ROOT_W    = 31;
  localparam int RAD_W     = 61;

  // Register stages in each unit.
  localparam int CORDIC_LAT = ITERS + 4;
  localparam int SQRT_LAT   = ROOT_W;

  // atan(2**-i) as a 32-bit binary angle, 2**31 equals pi.
  localparam logic [31:0] ATAN_TAB [ITERS] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
    32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
    32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2FA,
    32'h0000517D, 32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
    32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051, 32'h00000029,
    32'h00000014, 32'h0000000A, 32'h00000005, 32'h00000003, 32'h00000001,
    32'h00000001
  };

endpackage

// ----- design/qte_isqrt.sv -----
// ----------------------------------------------------------------------------
// Pipelined integer square root
// Floor square root of an unsigned radicand, one result bit per stage.
// ----------------------------------------------------------------------------
module qte_isqrt import qte_pkg::*; (
  input  logic              clk,
  input  logic              en,
  input  logic [RAD_W-1:0]  rad,
  output logic [ROOT_W-1:0] root
);

  localparam int PAD_W = 2 * ROOT_W;
  localparam int RM_W  = ROOT_W + 4;

  logic [PAD_W-1:0]  sv [ROOT_W];
  logic [RM_W-1:0]   rm [ROOT_W];
  logic [ROOT_W-1:0] rt [ROOT_W];

  for (genvar j = 0; j < ROOT_W; j++) begin : g_stage
    logic [PAD_W-1:0]  pv;
    logic [RM_W-1:0]   prm;
    logic [ROOT_W-1:0] prt;
    logic [RM_W-1:0]   cur;
    logic [RM_W-1:0]   trial;

    // The first stage starts from the radicand with an empty remainder.
    if (j == 0) begin : g_first
      assign pv  = {{(PAD_W-RAD_W){1'b0}}, rad};
      assign prm = '0;
      assign prt = '0;
    end else begin : g_next
      assign pv  = sv[j-1];
      assign prm = rm[j-1];
      assign prt = rt[j-1];
    end

    // Bring down the next bit pair and try the next root bit.
    assign cur   = {prm[RM_W-3:0], pv[PAD_W-1-2*j -: 2]};
    assign trial = RM_W'({prt, 2'b01});

    always_ff @(posedge clk) begin
      if (en) begin
        sv[j] <= pv;
        if (cur >= trial) begin
          rm[j] <= cur - trial;
          rt[j] <= {prt[ROOT_W-2:0], 1'b1};
        end else begin
          rm[j] <= cur;
          rt[j] <= {prt[ROOT_W-2:0], 1'b0};
        end
      end
    end
  end

  assign root = rt[ROOT_W-1];

endmodule

// ----- design/qte_cordic.sv -----
// ----------------------------------------------------------------------------
// Pipelined CORDIC arctangent
// atan2(y, x) in vectoring mode: quadrant fold, normalization, one
// iteration per stage and rounding to the output angle width.
// ----------------------------------------------------------------------------
module qte_cordic import qte_pkg::*; #(
  parameter int ANGLE_WIDTH = 16
) (
  input  logic                          clk,
  input  logic                          en,
  input  logic signed [SUM_W-1:0]       x_in,
  input  logic signed [SUM_W-1:0]       y_in,
  output logic        [ANGLE_WIDTH-1:0] angle
);

  localparam int SH  = 32 - ANGLE_WIDTH;
  localparam int HSH = (SH > 0) ? SH - 1 : 0;
  localparam logic signed [ANG_W-1:0] HALF = (SH > 0) ? (ANG_W'(1) << HSH) : '0;
  localparam logic signed [ANG_W-1:0] QTURN = ANG_W'(1) << 30;

  logic signed [SUM_W:0]   xe, ye, fx, fy;
  logic signed [ANG_W-1:0] fz;
  logic        [SUM_W-1:0] ax, ay;

  logic signed [SUM_W:0]   c0_x, c0_y;
  logic signed [ANG_W-1:0] c0_z;
  logic        [SUM_W-1:0] c0_mag;
  logic                    c0_zero;

  logic        [NORM_W-1:0] m1, m2;
  logic signed [NORM_W-1:0] a1, b1, a2, b2;
  logic        [NORM_W-1:0] c1_mag;
  logic signed [NORM_W-1:0] c1_x, c1_y;
  logic signed [ANG_W-1:0]  c1_z;
  logic                     c1_zero;

  logic signed [CORD_W-1:0] cx [ITERS+1];
  logic signed [CORD_W-1:0] cy [ITERS+1];
  logic signed [ANG_W-1:0]  cz [ITERS+1];
  logic                     zf [ITERS+1];
  logic signed [ANG_W-1:0]  rnd;

  // Fold the left half plane onto the right by a quarter turn.
  always_comb begin
    xe = {x_in[SUM_W-1], x_in};
    ye = {y_in[SUM_W-1], y_in};
    ax = x_in[SUM_W-1] ? (~x_in + 1'b1) : x_in;
    ay = y_in[SUM_W-1] ? (~y_in + 1'b1) : y_in;
    if (xe < 0) begin
      if (ye >= 0) begin
        fx = ye;
        fy = -xe;
        fz = QTURN;
      end else begin
        fx = -ye;
        fy = xe;
        fz = -QTURN;
      end
    end else begin
      fx = xe;
      fy = ye;
      fz = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      c0_x    <= fx;
      c0_y    <= fy;
      c0_z    <= fz;
      c0_mag  <= (ax > ay) ? ax : ay;
      c0_zero <= (x_in == '0) && (y_in == '0);
    end
  end

  // Normalization, first half: shifts of 32, 16 and 8.
  always_comb begin
    m1 = {{(NORM_W-SUM_W){1'b0}}, c0_mag};
    a1 = {{(NORM_W-SUM_W-1){c0_x[SUM_W]}}, c0_x};
    b1 = {{(NORM_W-SUM_W-1){c0_y[SUM_W]}}, c0_y};
    for (int j = 0; j < 3; j++) begin
      if (m1 < (NORM_W'(1) << (NORM_W - 1 - (32 >> j)))) begin
        m1 = m1 << (32 >> j);
        a1 = a1 <<< (32 >> j);
        b1 = b1 <<< (32 >> j);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      c1_mag  <= m1;
      c1_x    <= a1;
      c1_y    <= b1;
      c1_z    <= c0_z;
      c1_zero <= c0_zero;
    end
  end

  // Normalization, second half: shifts of 4, 2 and 1.
  always_comb begin
    m2 = c1_mag;
    a2 = c1_x;
    b2 = c1_y;
    for (int j = 3; j < 6; j++) begin
      if (m2 < (NORM_W'(1) << (NORM_W - 1 - (32 >> j)))) begin
        m2 = m2 << (32 >> j);
        a2 = a2 <<< (32 >> j);
        b2 = b2 <<< (32 >> j);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      cx[0] <= {{(CORD_W-NORM_W){a2[NORM_W-1]}}, a2};
      cy[0] <= {{(CORD_W-NORM_W){b2[NORM_W-1]}}, b2};
      cz[0] <= c1_z;
      zf[0] <= c1_zero;
    end
  end

  // One micro-rotation per stage, always toward y equal to zero.
  for (genvar i = 0; i < ITERS; i++) begin : g_iter
    localparam logic signed [ANG_W-1:0] STEP = ANG_W'(ATAN_TAB[i]);

    always_ff @(posedge clk) begin
      if (en) begin
        zf[i+1] <= zf[i];
        if (!cy[i][CORD_W-1]) begin
          cx[i+1] <= cx[i] + (cy[i] >>> i);
          cy[i+1] <= cy[i] - (cx[i] >>> i);
          cz[i+1] <= cz[i] + STEP;
        end else begin
          cx[i+1] <= cx[i] - (cy[i] >>> i);
          cy[i+1] <= cy[i] + (cx[i] >>> i);
          cz[i+1] <= cz[i] - STEP;
        end
      end
    end
  end

  // Round to the output width; a zero vector gives angle zero.
  assign rnd = (cz[ITERS] + HALF) >>> SH;

  always_ff @(posedge clk) begin
    if (en) begin
      angle <= zf[ITERS] ? '0 : rnd[ANGLE_WIDTH-1:0];
    end
  end

endmodule

// ----- design/quaternion_to_euler_angles_top.sv -----
// ----------------------------------------------------------------------------
// Quaternion to ZYX Euler angles
// Converts a Q2 fixed-point attitude quaternion to roll, pitch and yaw
// binary angles, with pitch clamped at plus or minus a quarter turn.
// ----------------------------------------------------------------------------
// Usage: a request carries quat_w, quat_x, quat_y and quat_z on the input
// channel (in_valid / in_ready). Each request gives exactly one result on the
// output channel (out_valid / out_ready): roll_angle, pitch_angle, yaw_angle
// and pitch_clamped.
// Throughput: one request per clock cycle while the skid register is empty.
// Every arithmetic step has its own stage: the products, the sums, the square,
// a 31-stage square root and three 35-stage CORDIC units, so nothing is shared
// between requests.
// Reset: rst clears every valid bit, out_valid and skid_valid included; no
// request is in flight afterwards.
// Stall: a skid register behind the output register catches a result that
// arrives while the output register is full and out_ready is low; in_ready
// then falls and the whole pipeline holds until the skid register drains.
// ----------------------------------------------------------------------------
module quaternion_to_euler_angles_top import qte_pkg::*; #(
  parameter int QUAT_WIDTH  = 16,
  parameter int ANGLE_WIDTH = 16
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic signed [QUAT_WIDTH-1:0]  quat_w,
  input  logic signed [QUAT_WIDTH-1:0]  quat_x,
  input  logic signed [QUAT_WIDTH-1:0]  quat_y,
  input  logic signed [QUAT_WIDTH-1:0]  quat_z,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic signed [ANGLE_WIDTH-1:0] roll_angle,
  output logic signed [ANGLE_WIDTH-1:0] pitch_angle,
  output logic signed [ANGLE_WIDTH-1:0] yaw_angle,
  output logic                          pitch_clamped
);

  localparam int FB       = 2 * (QUAT_WIDTH - 2);
  localparam int RSH      = (FB >= FRAC_BITS) ? FB - FRAC_BITS : 0;
  localparam int LSH      = (FB < FRAC_BITS) ? FRAC_BITS - FB : 0;
  localparam int LAT      = 3 + SQRT_LAT + CORDIC_LAT;
  localparam int RY_DLY   = 1 + SQRT_LAT;
  localparam int S_DLY    = SQRT_LAT + 1;
  localparam int FLAG_DLY = SQRT_LAT + CORDIC_LAT + 1;
  localparam logic signed [SUM_W-1:0] ONE = SUM_W'(1) << FRAC_BITS;
  localparam logic [RAD_W-1:0] SQ_ONE = RAD_W'(1) << (2 * FRAC_BITS);
  localparam logic [ANGLE_WIDTH-1:0] QUARTER = ANGLE_WIDTH'(1) << (ANGLE_WIDTH - 2);

  // Product of two components brought to 30 fraction bits, floor rounding.
  function automatic logic signed [PROD_W-1:0] prod30(
    input logic signed [QUAT_WIDTH-1:0] a,
    input logic signed [QUAT_WIDTH-1:0] b
  );
    logic signed [2*QUAT_WIDTH-1:0] raw;
    logic signed [65:0]             wide;
    raw  = a * b;
    wide = {{(66-2*QUAT_WIDTH){raw[2*QUAT_WIDTH-1]}}, raw};
    wide = (wide >>> RSH) <<< LSH;
    return wide[PROD_W-1:0];
  endfunction

  function automatic logic signed [SUM_W-1:0] sx(input logic signed [PROD_W-1:0] p);
    return {{(SUM_W-PROD_W){p[PROD_W-1]}}, p};
  endfunction

  logic adv;
  logic vld [LAT];

  logic signed [PROD_W-1:0] p_wx, p_yz, p_xx, p_yy, p_wy, p_zx, p_wz, p_xy, p_zz;
  logic signed [SUM_W-1:0]  roll_y, roll_x, sine, yaw_y, yaw_x;

  logic signed [30:0]       s31;
  logic signed [61:0]       sq;
  logic [RAD_W-1:0]         rad;
  logic signed [30:0]       s_dly [S_DLY];
  logic [1:0]               flag_dly [FLAG_DLY];
  logic [ROOT_W-1:0]        root;

  logic [ANGLE_WIDTH-1:0]   roll_c, yaw_c, pitch_c;
  logic [ANGLE_WIDTH-1:0]   roll_d [RY_DLY];
  logic [ANGLE_WIDTH-1:0]   yaw_d [RY_DLY];

  logic [ANGLE_WIDTH-1:0]   fin_pitch;
  logic                     fin_clamp;

  logic                     skid_valid;
  logic [ANGLE_WIDTH-1:0]   skid_roll, skid_pitch, skid_yaw;
  logic                     skid_clamp;
  logic                     take;

  // The pipeline moves whenever the skid register is empty.
  assign adv      = !skid_valid;
  assign in_ready = adv;
  assign take     = out_valid && out_ready;

  // Valid bits travel alongside the data.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < LAT; i++) begin
        vld[i] <= 1'b0;
      end
    end else if (adv) begin
      vld[0] <= in_valid;
      for (int i = 1; i < LAT; i++) begin
        vld[i] <= vld[i-1];
      end
    end
  end

  // Stage 1: component products.
  always_ff @(posedge clk) begin
    if (adv) begin
      p_wx <= prod30(quat_w, quat_x);
      p_yz <= prod30(quat_y, quat_z);
      p_xx <= prod30(quat_x, quat_x);
      p_yy <= prod30(quat_y, quat_y);
      p_wy <= prod30(quat_w, quat_y);
      p_zx <= prod30(quat_z, quat_x);
      p_wz <= prod30(quat_w, quat_z);
      p_xy <= prod30(quat_x, quat_y);
      p_zz <= prod30(quat_z, quat_z);
    end
  end

  // Stage 2: the atan2 terms and the pitch sine.
  always_ff @(posedge clk) begin
    if (adv) begin
      roll_y <= (sx(p_wx) + sx(p_yz)) <<< 1;
      roll_x <= ONE - ((sx(p_xx) + sx(p_yy)) <<< 1);
      sine   <= (sx(p_wy) - sx(p_zx)) <<< 1;
      yaw_y  <= (sx(p_wz) + sx(p_xy)) <<< 1;
      yaw_x  <= ONE - ((sx(p_yy) + sx(p_zz)) <<< 1);
    end
  end

  // Stage 3: clamp test and the radicand 1 - s**2.
  assign s31 = sine[30:0];
  assign sq  = s31 * s31;

  always_ff @(posedge clk) begin
    if (adv) begin
      rad <= SQ_ONE - sq[RAD_W-1:0];
      s_dly[0] <= s31;
      flag_dly[0] <= {(sine >= ONE) || (sine <= -ONE), sine[SUM_W-1]};
      for (int i = 1; i < S_DLY; i++) begin
        s_dly[i] <= s_dly[i-1];
      end
      for (int i = 1; i < FLAG_DLY; i++) begin
        flag_dly[i] <= flag_dly[i-1];
      end
    end
  end

  qte_isqrt u_isqrt (
    .clk  (clk),
    .en   (adv),
    .rad  (rad),
    .root (root)
  );

  // Pitch as atan2(s, sqrt(1 - s**2)).
  qte_cordic #(.ANGLE_WIDTH(ANGLE_WIDTH)) u_pitch (
    .clk   (clk),
    .en    (adv),
    .x_in  ({{(SUM_W-ROOT_W){1'b0}}, root}),
    .y_in  ({{(SUM_W-31){s_dly[S_DLY-1][30]}}, s_dly[S_DLY-1]}),
    .angle (pitch_c)
  );

  qte_cordic #(.ANGLE_WIDTH(ANGLE_WIDTH)) u_roll (
    .clk   (clk),
    .en    (adv),
    .x_in  (roll_x),
    .y_in  (roll_y),
    .angle (roll_c)
  );

  qte_cordic #(.ANGLE_WIDTH(ANGLE_WIDTH)) u_yaw (
    .clk   (clk),
    .en    (adv),
    .x_in  (yaw_x),
    .y_in  (yaw_y),
    .angle (yaw_c)
  );

  // Roll and yaw wait for the square root in front of the pitch CORDIC.
  always_ff @(posedge clk) begin
    if (adv) begin
      roll_d[0] <= roll_c;
      yaw_d[0]  <= yaw_c;
      for (int i = 1; i < RY_DLY; i++) begin
        roll_d[i] <= roll_d[i-1];
        yaw_d[i]  <= yaw_d[i-1];
      end
    end
  end

  // A clamped sine gives a quarter turn with its sign.
  assign fin_clamp = flag_dly[FLAG_DLY-1][1];
  assign fin_pitch = fin_clamp ? (flag_dly[FLAG_DLY-1][0] ? (~QUARTER + 1'b1) : QUARTER)
                               : pitch_c;

  // Output register with a skid register behind it.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (skid_valid) begin
      if (take) begin
        roll_angle    <= skid_roll;
        pitch_angle   <= skid_pitch;
        yaw_angle     <= skid_yaw;
        pitch_clamped <= skid_clamp;
        skid_valid    <= 1'b0;
      end
    end else if (vld[LAT-1]) begin
      if (!out_valid || take) begin
        roll_angle    <= roll_d[RY_DLY-1];
        pitch_angle   <= fin_pitch;
        yaw_angle     <= yaw_d[RY_DLY-1];
        pitch_clamped <= fin_clamp;
        out_valid     <= 1'b1;
      end else begin
        skid_roll  <= roll_d[RY_DLY-1];
        skid_pitch <= fin_pitch;
        skid_yaw   <= yaw_d[RY_DLY-1];
        skid_clamp <= fin_clamp;
        skid_valid <= 1'b1;
      end
    end else if (take) begin
      out_valid <= 1'b0;
    end
  end

endmodule
